[sv/swmm_pkg.sv]
// Shared types and constants for the sliding-window min/max unit.
// No dependencies; every other file of the block imports this package.
package swmm_pkg;

    // Field widths fixed by the stream format
    localparam int SAMPLE_W       = 32;
    localparam int WIN_SIZE_W     = 11;
    localparam int WINDOW_MAX_DEF = 1024;

    // Control broadcast from a queue to each of its cells
    typedef struct packed {
        logic                       load;   // a sample word is being taken
        logic                       clear;  // sequence ends with this word
        logic                       shift;  // whole row moves one toward the head
        logic signed [SAMPLE_W-1:0] key;    // incoming sample
    } cell_ctl_t;

endpackage

[sv/sliding_window_min_max_unit.sv]
// Sliding-window minimum and maximum over a stream of signed 32-bit sample words.
// Each accepted word updates two monotonic queues (min and max), each a row of
// WINDOW_MAX cells that compare against it and move together, so a word is taken
// every clock unless a result waits with m_ready low; a result appears in the
// cycle after its sample is accepted and is held until taken. Results start once
// window_size samples of a sequence have arrived; a word marked last ends the
// sequence and empties both queues. window_size must be written through the cfg
// port while idle (the block does not enforce it); zero acts as 1 and values
// above WINDOW_MAX saturate. Depends on swmm_pkg, swmm_queue and swmm_cell.
module sliding_window_min_max_unit
    import swmm_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration write
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [WIN_SIZE_W-1:0]      cfg_window_size,
    // sample stream
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    input  logic                       s_last_sample,
    // result stream
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [SAMPLE_W-1:0] m_window_min,
    output logic signed [SAMPLE_W-1:0] m_window_max,
    output logic                       m_last_result
);

    localparam int POS_W = $clog2(2 * WINDOW_MAX);
    localparam int CMP_W = (POS_W + 1 > WIN_SIZE_W) ? POS_W + 1 : WIN_SIZE_W;
    localparam logic [POS_W-1:0] POS_LAST  = POS_W'(2 * WINDOW_MAX - 1);
    localparam logic [CMP_W-1:0] WIN_LIMIT = CMP_W'(WINDOW_MAX);

    logic [CMP_W-1:0]           win_reg;
    logic [CMP_W-1:0]           win_next;
    logic [CMP_W-1:0]           cfg_ext;
    logic [POS_W-1:0]           pos_reg;
    logic [POS_W-1:0]           pos_next;
    logic                       filled_reg;
    logic                       filled_now;
    logic                       m_valid_reg;
    logic signed [SAMPLE_W-1:0] min_reg;
    logic signed [SAMPLE_W-1:0] max_reg;
    logic                       last_reg;
    logic                       accept;
    logic signed [SAMPLE_W-1:0] min_head;
    logic signed [SAMPLE_W-1:0] max_head;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;

    // window size clamped to 1..WINDOW_MAX at write
    always_comb begin
        cfg_ext = CMP_W'(cfg_window_size);
        if (cfg_ext == '0) begin
            win_next = CMP_W'(1);
        end else if (cfg_ext > WIN_LIMIT) begin
            win_next = WIN_LIMIT;
        end else begin
            win_next = cfg_ext;
        end
    end

    // position counter and fill flag
    always_comb begin
        filled_now = filled_reg || ((CMP_W'(pos_reg) + CMP_W'(1)) >= win_reg);
        if (s_last_sample || pos_reg == POS_LAST) begin
            pos_next = '0;
        end else begin
            pos_next = pos_reg + POS_W'(1);
        end
    end

    swmm_queue #(
        .WINDOW_MAX (WINDOW_MAX),
        .IS_MAX     (1'b0)
    ) u_min_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (accept),
        .clear   (s_last_sample),
        .key     (s_sample),
        .in_pos  (pos_reg),
        .win     (win_reg),
        .head    (min_head)
    );

    swmm_queue #(
        .WINDOW_MAX (WINDOW_MAX),
        .IS_MAX     (1'b1)
    ) u_max_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (accept),
        .clear   (s_last_sample),
        .key     (s_sample),
        .in_pos  (pos_reg),
        .win     (win_reg),
        .head    (max_head)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg     <= CMP_W'(1);
            pos_reg     <= '0;
            filled_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                win_reg <= win_next;
            end
            if (accept) begin
                pos_reg     <= pos_next;
                filled_reg  <= filled_now && !s_last_sample;
                m_valid_reg <= filled_now;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result word register
    always_ff @(posedge aclk) begin
        if (accept) begin
            min_reg  <= min_head;
            max_reg  <= max_head;
            last_reg <= s_last_sample;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_window_min  = min_reg;
    assign m_window_max  = max_reg;
    assign m_last_result = last_reg;

endmodule

[sv/swmm_cell.sv]
// One cell of a monotonic-queue row: holds a sample value, its position and a valid bit.
// Depends on swmm_pkg (cell_ctl_t, SAMPLE_W).
module swmm_cell
    import swmm_pkg::*;
#(
    parameter int POS_W  = 11,
    parameter bit IS_MAX = 1'b0
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  cell_ctl_t                  ctl,
    input  logic [POS_W-1:0]           in_pos,
    // neighbor toward the tail
    input  logic                       right_valid,
    input  logic signed [SAMPLE_W-1:0] right_value,
    input  logic [POS_W-1:0]           right_pos,
    input  logic                       right_drop,
    // neighbor toward the head keeps its entry
    input  logic                       left_keep,
    output logic                       cell_valid,
    output logic signed [SAMPLE_W-1:0] cell_value,
    output logic [POS_W-1:0]           cell_pos,
    output logic                       cell_drop,
    output logic                       cell_keep,
    output logic signed [SAMPLE_W-1:0] value_next
);

    logic                       valid_reg;
    logic signed [SAMPLE_W-1:0] value_reg;
    logic [POS_W-1:0]           pos_reg;

    logic                       e_valid;
    logic                       e_drop;
    logic signed [SAMPLE_W-1:0] e_value;
    logic [POS_W-1:0]           e_pos;
    logic [POS_W-1:0]           pos_next;
    logic                       valid_next;

    // entry made useless by the new sample (drops form a suffix of the row)
    always_comb begin
        if (IS_MAX) begin
            cell_drop = valid_reg && (value_reg <= ctl.key);
        end else begin
            cell_drop = valid_reg && (value_reg >= ctl.key);
        end
    end

    // content after an optional move toward the head
    always_comb begin
        e_valid = ctl.shift ? right_valid : valid_reg;
        e_drop  = ctl.shift ? right_drop  : cell_drop;
        e_value = ctl.shift ? right_value : value_reg;
        e_pos   = ctl.shift ? right_pos   : pos_reg;
    end

    // keep own entry, or take the new sample if this is the first free slot
    always_comb begin
        cell_keep  = e_valid && !e_drop;
        value_next = cell_keep ? e_value : ctl.key;
        pos_next   = cell_keep ? e_pos : in_pos;
        valid_next = !ctl.clear && (cell_keep || left_keep);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctl.load) begin
            valid_reg <= valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            value_reg <= value_next;
            pos_reg   <= pos_next;
        end
    end

    assign cell_valid = valid_reg;
    assign cell_value = value_reg;
    assign cell_pos   = pos_reg;

endmodule

[sv/swmm_queue.sv]
// Monotonic queue built as a row of swmm_cell instances, head at cell 0.
// Depends on swmm_pkg and swmm_cell.
module swmm_queue
    import swmm_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF,
    parameter bit IS_MAX     = 1'b0,
    localparam int POS_W     = $clog2(2 * WINDOW_MAX),
    localparam int CMP_W     = (POS_W + 1 > WIN_SIZE_W) ? POS_W + 1 : WIN_SIZE_W
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       load,
    input  logic                       clear,
    input  logic signed [SAMPLE_W-1:0] key,
    input  logic [POS_W-1:0]           in_pos,
    input  logic [CMP_W-1:0]           win,
    output logic signed [SAMPLE_W-1:0] head
);

    localparam int          N       = WINDOW_MAX;
    localparam logic [POS_W:0] POS_MOD = (POS_W + 1)'(2 * WINDOW_MAX);

    logic                       c_valid [N];
    logic signed [SAMPLE_W-1:0] c_value [N];
    logic [POS_W-1:0]           c_pos   [N];
    logic                       c_drop  [N];
    logic                       c_keep  [N];
    logic signed [SAMPLE_W-1:0] c_next  [N];

    logic [POS_W:0]   diff;
    logic [POS_W:0]   age_wrap;
    logic [POS_W-1:0] age;
    logic             evict;
    cell_ctl_t        ctl;

    // head age modulo twice the window bound
    always_comb begin
        diff     = {1'b0, in_pos} - {1'b0, c_pos[0]};
        age_wrap = diff[POS_W] ? (diff + POS_MOD) : diff;
        age      = age_wrap[POS_W-1:0];
        evict    = c_valid[0] && (CMP_W'(age) >= win);
    end

    // move row on a stale head, or on a full row that nothing pops
    always_comb begin
        ctl.load  = load;
        ctl.clear = clear;
        ctl.key   = key;
        ctl.shift = evict || (c_valid[N-1] && !c_drop[N-1]);
    end

    for (genvar i = 0; i < N; i++) begin : g_cell
        logic                       r_valid;
        logic signed [SAMPLE_W-1:0] r_value;
        logic [POS_W-1:0]           r_pos;
        logic                       r_drop;
        logic                       l_keep;

        if (i == N - 1) begin : g_tail
            assign r_valid = 1'b0;
            assign r_value = '0;
            assign r_pos   = '0;
            assign r_drop  = 1'b0;
        end else begin : g_mid
            assign r_valid = c_valid[i+1];
            assign r_value = c_value[i+1];
            assign r_pos   = c_pos[i+1];
            assign r_drop  = c_drop[i+1];
        end

        if (i == 0) begin : g_head
            assign l_keep = 1'b1;
        end else begin : g_body
            assign l_keep = c_keep[i-1];
        end

        swmm_cell #(
            .POS_W  (POS_W),
            .IS_MAX (IS_MAX)
        ) u_cell (
            .aclk        (aclk),
            .aresetn     (aresetn),
            .ctl         (ctl),
            .in_pos      (in_pos),
            .right_valid (r_valid),
            .right_value (r_value),
            .right_pos   (r_pos),
            .right_drop  (r_drop),
            .left_keep   (l_keep),
            .cell_valid  (c_valid[i]),
            .cell_value  (c_value[i]),
            .cell_pos    (c_pos[i]),
            .cell_drop   (c_drop[i]),
            .cell_keep   (c_keep[i]),
            .value_next  (c_next[i])
        );
    end

    // head after this sample's update
    assign head = c_next[0];

endmodule
